@@ rtl/core/mfa_pkg.sv @@
// Shared types and constants for the 256-bit modular field arithmetic unit.
`default_nettype none

package mfa_pkg;

  // Operand geometry.
  localparam int OPERAND_BYTES = 32;
  localparam int NBITS         = OPERAND_BYTES * 8;
  localparam int WORD_W        = 64;
  localparam int NWORDS        = NBITS / WORD_W;
  localparam int CNT_W         = $clog2(NBITS);
  localparam int EXT_W         = NBITS + 2;

  // Configuration port geometry and register indexes.
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_MODULUS_WORD0 = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_MODULUS_WORD1 = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_MODULUS_WORD2 = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_MODULUS_WORD3 = CFG_IDX_W'(3);

  // Highest bit index of an operand, where every bit loop starts.
  localparam logic [CNT_W-1:0] TOP_BIT = CNT_W'(NBITS - 1);

  // Operation codes carried in the input word.
  typedef enum logic [1:0] {
    MODE_ADD = 2'd0,
    MODE_SUB = 2'd1,
    MODE_MUL = 2'd2,
    MODE_INV = 2'd3
  } mode_t;

  // Operation of the shared modular adder.
  typedef enum logic {
    ALU_ADD = 1'b0,
    ALU_SUB = 1'b1
  } alu_op_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_ADDSUB,
    S_INV_SETUP,
    S_MUL_DBL,
    S_MUL_ADD,
    S_DONE
  } state_t;

  // Input word.
  typedef struct packed {
    mode_t             mode;
    logic [WORD_W-1:0] a_word0;
    logic [WORD_W-1:0] a_word1;
    logic [WORD_W-1:0] a_word2;
    logic [WORD_W-1:0] a_word3;
    logic [WORD_W-1:0] b_word0;
    logic [WORD_W-1:0] b_word1;
    logic [WORD_W-1:0] b_word2;
    logic [WORD_W-1:0] b_word3;
  } in_item_t;

  // Result word.
  typedef struct packed {
    logic [WORD_W-1:0] result_word0;
    logic [WORD_W-1:0] result_word1;
    logic [WORD_W-1:0] result_word2;
    logic [WORD_W-1:0] result_word3;
  } out_item_t;

  // Control from the top level to the sequencer.
  typedef struct packed {
    logic start;
    logic done_ready;
  } seq_ctrl_t;

  // Status from the sequencer to the top level.
  typedef struct packed {
    logic idle;
    logic done_valid;
  } seq_stat_t;

endpackage

`default_nettype wire

@@ rtl/core/mfa_addsub.sv @@
// Shared 256-bit modular adder/subtractor with conditional modulus correction.
`default_nettype none

module mfa_addsub (
  input  mfa_pkg::alu_op_t          op,
  input  logic [mfa_pkg::NBITS-1:0] x,
  input  logic [mfa_pkg::NBITS-1:0] y,
  input  logic [mfa_pkg::NBITS-1:0] m,
  output logic [mfa_pkg::NBITS-1:0] r
);
  import mfa_pkg::*;

  logic [EXT_W-1:0] xe;
  logic [EXT_W-1:0] ye;
  logic [EXT_W-1:0] me;
  logic [EXT_W-1:0] prim;
  logic [EXT_W-1:0] alt;
  logic             use_alt;

  assign xe = {2'b00, x};
  assign ye = {2'b00, y};
  assign me = {2'b00, m};

  // Plain result and the corrected one are formed side by side.
  always_comb begin
    if (op == ALU_SUB) begin
      prim    = xe - ye;
      alt     = xe - ye + me;
      // A borrow out of the difference calls for the modulus add-back.
      use_alt = prim[EXT_W-1];
    end else begin
      prim    = xe + ye;
      alt     = xe + ye - me;
      // The full sum at or above the modulus takes the reduced value.
      use_alt = ~alt[EXT_W-1];
    end
  end

  assign r = use_alt ? alt[NBITS-1:0] : prim[NBITS-1:0];

endmodule

`default_nettype wire

@@ rtl/core/mfa_seq.sv @@
// Sequencer and operand registers driving the shared modular adder.
`default_nettype none

module mfa_seq (
  input  logic                      clk,
  input  logic                      rst_n,
  input  mfa_pkg::seq_ctrl_t        ctrl,
  input  mfa_pkg::in_item_t         in_item,
  input  logic [mfa_pkg::NBITS-1:0] modulus,
  output mfa_pkg::seq_stat_t        stat,
  output logic [mfa_pkg::NBITS-1:0] result
);
  import mfa_pkg::*;

  localparam logic [NBITS-1:0] ONE = NBITS'(1);

  state_t           state_r, state_nxt;
  mode_t            mode_r, mode_nxt;
  logic [CNT_W-1:0] bit_cnt_r, bit_cnt_nxt;
  logic [CNT_W-1:0] exp_cnt_r, exp_cnt_nxt;
  logic             sq_phase_r, sq_phase_nxt;
  logic [NBITS-1:0] a_r, a_nxt;
  logic [NBITS-1:0] mx_r, mx_nxt;
  logic [NBITS-1:0] my_r, my_nxt;
  logic [NBITS-1:0] acc_r, acc_nxt;
  logic [NBITS-1:0] cur_r, cur_nxt;
  logic [NBITS-1:0] exp_r, exp_nxt;

  logic [NBITS-1:0] in_a;
  logic [NBITS-1:0] in_b;
  alu_op_t          alu_op;
  logic [NBITS-1:0] alu_x;
  logic [NBITS-1:0] alu_y;
  logic [NBITS-1:0] alu_r;

  assign in_a = {in_item.a_word3, in_item.a_word2, in_item.a_word1, in_item.a_word0};
  assign in_b = {in_item.b_word3, in_item.b_word2, in_item.b_word1, in_item.b_word0};

  // Operand selection for the shared unit.
  always_comb begin
    alu_op = ALU_ADD;
    alu_x  = acc_r;
    alu_y  = acc_r;
    unique case (state_r)
      S_ADDSUB: begin
        alu_op = (mode_r == MODE_SUB) ? ALU_SUB : ALU_ADD;
        alu_x  = a_r;
        alu_y  = my_r;
      end
      S_MUL_ADD: begin
        alu_y = my_r[NBITS-1] ? mx_r : '0;
      end
      default: begin
        alu_op = ALU_ADD;
      end
    endcase
  end

  mfa_addsub u_addsub (
    .op (alu_op),
    .x  (alu_x),
    .y  (alu_y),
    .m  (modulus),
    .r  (alu_r)
  );

  // Next state and datapath updates.
  always_comb begin
    state_nxt    = state_r;
    mode_nxt     = mode_r;
    bit_cnt_nxt  = bit_cnt_r;
    exp_cnt_nxt  = exp_cnt_r;
    sq_phase_nxt = sq_phase_r;
    a_nxt        = a_r;
    mx_nxt       = mx_r;
    my_nxt       = my_r;
    acc_nxt      = acc_r;
    cur_nxt      = cur_r;
    exp_nxt      = exp_r;
    unique case (state_r)
      S_IDLE: begin
        if (ctrl.start) begin
          mode_nxt     = in_item.mode;
          a_nxt        = in_a;
          mx_nxt       = in_a;
          my_nxt       = in_b;
          acc_nxt      = '0;
          cur_nxt      = '0;
          exp_nxt      = modulus - NBITS'(2);
          bit_cnt_nxt  = TOP_BIT;
          exp_cnt_nxt  = TOP_BIT;
          sq_phase_nxt = 1'b0;
          unique case (in_item.mode)
            MODE_ADD, MODE_SUB: state_nxt = S_ADDSUB;
            MODE_MUL:           state_nxt = S_MUL_DBL;
            MODE_INV:           state_nxt = (in_a == '0) ? S_DONE : S_INV_SETUP;
            default:            state_nxt = S_IDLE;
          endcase
        end
      end
      S_ADDSUB: begin
        acc_nxt   = alu_r;
        state_nxt = S_DONE;
      end
      // The square starts at one; the first multiplier follows the top exponent bit.
      S_INV_SETUP: begin
        mx_nxt    = ONE;
        my_nxt    = exp_r[NBITS-1] ? a_r : ONE;
        acc_nxt   = '0;
        state_nxt = S_MUL_DBL;
      end
      S_MUL_DBL: begin
        acc_nxt   = alu_r;
        state_nxt = S_MUL_ADD;
      end
      S_MUL_ADD: begin
        acc_nxt   = alu_r;
        my_nxt    = {my_r[NBITS-2:0], 1'b0};
        state_nxt = S_MUL_DBL;
        if (bit_cnt_r != '0) begin
          bit_cnt_nxt = bit_cnt_r - CNT_W'(1);
        end else begin
          bit_cnt_nxt = TOP_BIT;
          acc_nxt     = '0;
          if (mode_r != MODE_INV) begin
            acc_nxt   = alu_r;
            state_nxt = S_DONE;
          end else if (!sq_phase_r) begin
            // Product done; square it next.
            cur_nxt      = alu_r;
            mx_nxt       = alu_r;
            my_nxt       = alu_r;
            sq_phase_nxt = 1'b1;
          end else if (exp_cnt_r == '0) begin
            state_nxt = S_DONE;
          end else begin
            // Square done; multiply by a or one for the next exponent bit.
            exp_cnt_nxt  = exp_cnt_r - CNT_W'(1);
            exp_nxt      = {exp_r[NBITS-2:0], 1'b0};
            mx_nxt       = alu_r;
            my_nxt       = exp_r[NBITS-2] ? a_r : ONE;
            sq_phase_nxt = 1'b0;
          end
        end
      end
      S_DONE: begin
        if (ctrl.done_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      mode_r     <= MODE_ADD;
      bit_cnt_r  <= '0;
      exp_cnt_r  <= '0;
      sq_phase_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      mode_r     <= mode_nxt;
      bit_cnt_r  <= bit_cnt_nxt;
      exp_cnt_r  <= exp_cnt_nxt;
      sq_phase_r <= sq_phase_nxt;
    end
  end

  // Operand and accumulator registers.
  always_ff @(posedge clk) begin
    a_r   <= a_nxt;
    mx_r  <= mx_nxt;
    my_r  <= my_nxt;
    acc_r <= acc_nxt;
    cur_r <= cur_nxt;
    exp_r <= exp_nxt;
  end

  assign stat.idle       = (state_r == S_IDLE);
  assign stat.done_valid = (state_r == S_DONE);
  assign result          = (mode_r == MODE_INV) ? cur_r : acc_r;

endmodule

`default_nettype wire

@@ rtl/core/modular_field_alu_256_core.sv @@
// Top level of the 256-bit modular field arithmetic unit.
//
//  Channel  Ports                                     Moves
//  in       in_valid, in_ready, in_data               mode, operands a and b
//  out      out_valid, out_ready, out_data            256-bit result
//  cfg      cfg_we, cfg_index, cfg_data               modulus words 0 to 3
//
// Add and subtract take one pass of the shared modular adder. Multiply runs
// 256 bits of double-and-add, each two passes of that adder. Inverse does two
// multiplies per exponent bit; an operand of zero returns zero.
// Reset is synchronous and active low and clears the control state and the modulus.
// A new word is accepted while a finished result waits in the output register.
`default_nettype none

module modular_field_alu_256_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  mfa_pkg::in_item_t             in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output mfa_pkg::out_item_t            out_data,
  input  logic                          cfg_we,
  input  logic [mfa_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [mfa_pkg::WORD_W-1:0]    cfg_data
);
  import mfa_pkg::*;

  logic [WORD_W-1:0] mod_r   [NWORDS];
  logic [NBITS-1:0]  modulus;
  seq_ctrl_t         ctrl;
  seq_stat_t         stat;
  logic [NBITS-1:0]  seq_result;
  logic              load_out;
  logic              out_valid_r, out_valid_nxt;
  out_item_t         out_data_r;

  // Modulus registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NWORDS; i++) begin
        mod_r[i] <= '0;
      end
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MODULUS_WORD0: mod_r[0] <= cfg_data;
        REG_MODULUS_WORD1: mod_r[1] <= cfg_data;
        REG_MODULUS_WORD2: mod_r[2] <= cfg_data;
        REG_MODULUS_WORD3: mod_r[3] <= cfg_data;
        default: ;
      endcase
    end
  end

  assign modulus = {mod_r[3], mod_r[2], mod_r[1], mod_r[0]};

  // Handshake with the sequencer.
  assign in_ready        = stat.idle;
  assign ctrl.start      = in_valid & stat.idle;
  assign ctrl.done_ready = ~out_valid_r | out_ready;
  assign load_out        = stat.done_valid & ctrl.done_ready;

  mfa_seq u_seq (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctrl    (ctrl),
    .in_item (in_data),
    .modulus (modulus),
    .stat    (stat),
    .result  (seq_result)
  );

  // Output register.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_data_r.result_word0 <= seq_result[WORD_W-1:0];
      out_data_r.result_word1 <= seq_result[2*WORD_W-1:WORD_W];
      out_data_r.result_word2 <= seq_result[3*WORD_W-1:2*WORD_W];
      out_data_r.result_word3 <= seq_result[4*WORD_W-1:3*WORD_W];
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

@@ verif/modular_field_alu_256_core_tb.sv @@
// Self-checking testbench for the 256-bit modular field arithmetic unit.
module modular_field_alu_256_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import mfa_pkg::*;

  localparam int CYCLE_LIMIT = 4_000_000;
  localparam int HOLD_CYCLES = 400;
  localparam int MAX_GAP     = 20;
  localparam int MAX_PRINTED = 40;

  localparam logic [255:0] NIST_P256 = {64'hFFFFFFFF00000001, 64'h0000000000000000,
                                        64'h00000000FFFFFFFF, 64'hFFFFFFFFFFFFFFFF};
  localparam logic [255:0] ALL_ONES  = {256{1'b1}};

  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 in_valid  = 1'b0;
  logic                 in_ready;
  in_item_t             in_data   = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  out_item_t            out_data;
  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_MODULUS_WORD0;
  logic [WORD_W-1:0]    cfg_data  = '0;

  // Testbench copy of the modulus and the results still owed by the block.
  logic [255:0] modulus_value = '0;
  out_item_t    expected_results[$];

  int error_count   = 0;
  int cycle_count   = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_requests = 0;
  int hold_taken    = 0;
  int hold_left     = 0;

  modular_field_alu_256_core uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  // Modular add: the 257-bit sum loses the modulus once when it reaches it.
  function automatic logic [255:0] field_add(input logic [255:0] x, input logic [255:0] y);
    logic [256:0] sum;
    sum = {1'b0, x} + {1'b0, y};
    if (sum >= {1'b0, modulus_value}) return sum[255:0] - modulus_value;
    return sum[255:0];
  endfunction

  // Modular subtract: a borrow adds the modulus back, wrapping at 2^256.
  function automatic logic [255:0] field_sub(input logic [255:0] x, input logic [255:0] y);
    if (x < y) return x - y + modulus_value;
    return x - y;
  endfunction

  // Double-and-add over the bits of y, most significant first.
  function automatic logic [255:0] field_mul(input logic [255:0] x, input logic [255:0] y);
    logic [255:0] acc;
    acc = '0;
    for (int k = 255; k >= 0; k--) begin
      acc = field_add(acc, acc);
      acc = field_add(acc, y[k] ? x : 256'd0);
    end
    return acc;
  endfunction

  // Fermat inverse x^(m-2), square-and-multiply; zero maps to zero.
  function automatic logic [255:0] field_inv(input logic [255:0] x);
    logic [255:0] expo, sq, cur;
    if (x == '0) return '0;
    expo = modulus_value - 256'd2;
    sq   = 256'd1;
    cur  = '0;
    for (int k = 255; k >= 0; k--) begin
      cur = field_mul(sq, expo[k] ? x : 256'd1);
      sq  = field_mul(cur, cur);
    end
    return cur;
  endfunction

  function automatic out_item_t field_result(input in_item_t w);
    logic [255:0] a, b, r;
    out_item_t    res;
    a = {w.a_word3, w.a_word2, w.a_word1, w.a_word0};
    b = {w.b_word3, w.b_word2, w.b_word1, w.b_word0};
    r = '0;
    case (w.mode)
      MODE_ADD: r = field_add(a, b);
      MODE_SUB: r = field_sub(a, b);
      MODE_MUL: r = field_mul(a, b);
      MODE_INV: r = field_inv(a);
    endcase
    res.result_word0 = r[63:0];
    res.result_word1 = r[127:64];
    res.result_word2 = r[191:128];
    res.result_word3 = r[255:192];
    return res;
  endfunction

  function automatic in_item_t make_word(input mode_t md, input logic [255:0] a,
                                         input logic [255:0] b);
    in_item_t w;
    w.mode    = md;
    w.a_word0 = a[63:0];
    w.a_word1 = a[127:64];
    w.a_word2 = a[191:128];
    w.a_word3 = a[255:192];
    w.b_word0 = b[63:0];
    w.b_word1 = b[127:64];
    w.b_word2 = b[191:128];
    w.b_word3 = b[255:192];
    return w;
  endfunction

  function automatic logic [255:0] random_256();
    return {$urandom(), $urandom(), $urandom(), $urandom(),
            $urandom(), $urandom(), $urandom(), $urandom()};
  endfunction

  // Mostly reduced operands, with edge values and some unreduced ones mixed in.
  function automatic logic [255:0] random_operand();
    int           pick;
    logic [255:0] raw;
    pick = $urandom_range(99);
    raw  = random_256();
    if (pick < 6) return '0;
    if (pick < 12) return modulus_value - 256'd1;
    if (pick < 16) return 256'd1;
    if (pick < 26 || modulus_value == '0) return raw;
    return raw % modulus_value;
  endfunction

  // A nonzero inverse takes two full multiplies per exponent bit, so random
  // inverses take a zero operand; nonzero ones are covered by directed words.
  function automatic in_item_t random_word();
    int           pick;
    mode_t        md;
    logic [255:0] a, b;
    pick = $urandom_range(99);
    if (pick < 35) md = MODE_ADD;
    else if (pick < 70) md = MODE_SUB;
    else if (pick < 95) md = MODE_MUL;
    else md = MODE_INV;
    a = random_operand();
    b = random_operand();
    if (md == MODE_INV) a = '0;
    return make_word(md, a, b);
  endfunction

  task automatic report_mismatch(input string what);
    if (error_count < MAX_PRINTED) $display("[%0d] mismatch: %s", cycle_count, what);
    error_count++;
  endtask

  task automatic check_field(input string field, input logic [63:0] got,
                             input logic [63:0] want);
    if (got !== want) report_mismatch($sformatf("%s got %h expected %h", field, got, want));
  endtask

  // Send one word, with a random gap first; called right after a rising edge.
  task automatic send_word(input in_item_t w);
    int gaps;
    gaps = 0;
    while (gaps < MAX_GAP && $urandom_range(99) < send_idle_pct) gaps++;
    if (gaps > 0) begin
      in_valid <= 1'b0;
      repeat (gaps) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (!in_ready);
    expected_results.push_back(field_result(w));
  endtask

  // Stop offering words and wait until every owed result has come back.
  task automatic finish_phase();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  // Write all four modulus words; the block must be idle.
  task automatic load_modulus(input logic [255:0] m);
    cfg_we    <= 1'b1;
    cfg_index <= REG_MODULUS_WORD0;
    cfg_data  <= m[63:0];
    @(posedge clk);
    cfg_index <= REG_MODULUS_WORD1;
    cfg_data  <= m[127:64];
    @(posedge clk);
    cfg_index <= REG_MODULUS_WORD2;
    cfg_data  <= m[191:128];
    @(posedge clk);
    cfg_index <= REG_MODULUS_WORD3;
    cfg_data  <= m[255:192];
    @(posedge clk);
    cfg_we <= 1'b0;
    modulus_value = m;
  endtask

  // Edge operands for every operation under the P-256 prime.
  task automatic test_directed_prime();
    logic [255:0] pm1;
    load_modulus(NIST_P256);
    pm1 = NIST_P256 - 256'd1;
    send_word(make_word(MODE_ADD, '0, '0));
    send_word(make_word(MODE_ADD, pm1, pm1));
    send_word(make_word(MODE_ADD, pm1, 256'd1));
    send_word(make_word(MODE_SUB, '0, 256'd1));
    send_word(make_word(MODE_SUB, pm1, pm1));
    send_word(make_word(MODE_SUB, 256'd1, pm1));
    send_word(make_word(MODE_MUL, pm1, pm1));
    send_word(make_word(MODE_MUL, random_256() % NIST_P256, '0));
    send_word(make_word(MODE_MUL, 256'd1, random_256() % NIST_P256));
    // Inverse of zero gives zero; b is ignored.
    send_word(make_word(MODE_INV, '0, ALL_ONES));
    send_word(make_word(MODE_INV, 256'd3, '0));
    // Operands above the modulus are not reduced first.
    send_word(make_word(MODE_ADD, ALL_ONES, ALL_ONES));
    send_word(make_word(MODE_SUB, '0, ALL_ONES));
    send_word(make_word(MODE_MUL, ALL_ONES, ALL_ONES));
    finish_phase();
  endtask

  // A zero modulus turns add and subtract into plain wrapping arithmetic.
  task automatic test_zero_modulus();
    load_modulus('0);
    send_word(make_word(MODE_ADD, ALL_ONES, 256'd1));
    send_word(make_word(MODE_SUB, '0, 256'd1));
    send_word(make_word(MODE_MUL, random_256(), random_256()));
    send_word(make_word(MODE_INV, '0, random_256()));
    send_word(make_word(MODE_INV, random_256() | 256'd1, '0));
    finish_phase();
  endtask

  task automatic test_random_traffic(input logic [255:0] m, input int count);
    load_modulus(m);
    for (int i = 0; i < count; i++) send_word(random_word());
    finish_phase();
  endtask

  // The receiver holds off while adds keep coming, so the block backs up.
  task automatic test_output_backpressure();
    hold_requests++;
    for (int i = 0; i < 12; i++)
      send_word(make_word(MODE_ADD, random_operand(), random_operand()));
    finish_phase();
  endtask

  // Receiver: random stalls, plus a long hold-off when one is requested.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_taken != hold_requests) begin
      hold_taken = hold_requests;
      hold_left  = HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Compare every accepted result with the oldest expectation.
  always @(posedge clk) begin : result_check
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        report_mismatch($sformatf("result %h with nothing expected", out_data));
      end else begin
        want = expected_results.pop_front();
        check_field("result_word0", out_data.result_word0, want.result_word0);
        check_field("result_word1", out_data.result_word1, want.result_word1);
        check_field("result_word2", out_data.result_word2, want.result_word2);
        check_field("result_word3", out_data.result_word3, want.result_word3);
      end
    end
  end

  // Watchdog.
  initial begin
    while (cycle_count < CYCLE_LIMIT) @(posedge clk);
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    logic [255:0] wide_modulus;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_idle_pct = 33;
    recv_idle_pct = 65;
    test_directed_prime();
    test_zero_modulus();
    wide_modulus      = random_256();
    wide_modulus[255] = 1'b1;
    test_random_traffic(wide_modulus, 150);
    test_random_traffic(256'($urandom_range(32'h000F_FFFF, 2)), 50);

    send_idle_pct = 65;
    recv_idle_pct = 33;
    test_random_traffic(ALL_ONES, 160);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_traffic(NIST_P256, 150);
    test_output_backpressure();

    // Let any stray result show up before the verdict.
    repeat (10) @(posedge clk);
    if (error_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
